// File: rtl/dbhfc_pkg.sv
// Package for the handshake flow classifier: codes, constants and word types.
`default_nettype none

package dbhfc_pkg;

   // Table size and length limits
   localparam int NUM_SLOTS_DEF = 1024;
   localparam logic [15:0] CAPTURE_MAX = 16'd30720;

   // Action codes of an input word
   localparam logic [1:0] ACT_OPEN   = 2'd0;
   localparam logic [1:0] ACT_PACKET = 2'd1;
   localparam logic [1:0] ACT_CLOSE  = 2'd2;

   // Open matching
   localparam logic [15:0] FAMILY_INET  = 16'd2;
   localparam logic [15:0] DEFAULT_PORT = 16'd3306;

   // Packet header checks
   localparam logic [7:0]  TYPE_GREETING    = 8'h0a;
   localparam logic [7:0]  TYPE_OK          = 8'h00;
   localparam logic [7:0]  TYPE_ERR         = 8'hFF;
   localparam logic [7:0]  SEQ_GREETING     = 8'd0;
   localparam logic [7:0]  SEQ_CLIENT_REPLY = 8'd1;
   localparam logic [15:0] GREETING_MIN_LEN = 16'd10;
   localparam logic [15:0] HEADER_LEN       = 16'd4;

   // Handshake progress of one connection
   typedef enum logic [2:0] {
      HS_CONNECTING  = 3'd0,
      HS_GREETING    = 3'd1,
      HS_AUTH        = 3'd2,
      HS_ESTABLISHED = 3'd3,
      HS_INVALID     = 3'd4
   } hs_state_type;

   // One table entry
   typedef struct packed {
      logic         tracked;
      hs_state_type state;
      logic         confirmed;
   } entry_type;

   // Input word
   typedef struct packed {
      logic [1:0]  action;
      logic [9:0]  conn_slot;
      logic [15:0] addr_family;
      logic [15:0] dest_port;
      logic        call_ok;
      logic        direction;
      logic [15:0] captured_length;
      logic [7:0]  len_byte0;
      logic [7:0]  len_byte1;
      logic [7:0]  len_byte2;
      logic [7:0]  seq_byte;
      logic [7:0]  type_byte;
   } req_type;

   // Result word
   typedef struct packed {
      logic [9:0]  event_slot;
      logic        event_direction;
      logic [14:0] event_length;
      logic [7:0]  event_seq;
      logic [2:0]  event_state;
      logic        event_confirmed;
   } rsp_type;

   // Outcome of one table update
   typedef struct packed {
      entry_type entry;
      logic      emit;
   } upd_type;

endpackage

`default_nettype wire

// File: rtl/dbhfc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module dbhfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read-first: a read at the write address returns the old contents
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/dbhfc_update.sv
// Next-entry and event logic for one word against its table entry.
`default_nettype none

module dbhfc_update (
   input  wire dbhfc_pkg::req_type   req,
   input  wire dbhfc_pkg::entry_type cur,
   input  wire logic [15:0]          extra_port,
   output      dbhfc_pkg::upd_type   upd,
   output      dbhfc_pkg::rsp_type   rsp
);

   import dbhfc_pkg::*;

   logic [15:0] len_clamped;
   logic [23:0] hdr_len;
   logic        port_match;
   logic        open_match;
   logic        pkt_live;
   logic        hdr_bad;
   entry_type   nxt;
   logic        emit;

   // Header decode and clamp
   assign len_clamped = (req.captured_length > CAPTURE_MAX) ? CAPTURE_MAX : req.captured_length;
   assign hdr_len     = {req.len_byte2, req.len_byte1, req.len_byte0};
   assign hdr_bad     = (len_clamped < HEADER_LEN) || (hdr_len == 24'd0) ||
                        (hdr_len > 24'(CAPTURE_MAX));

   // Open filter: fixed port, or the configured one when non-zero
   assign port_match = (req.dest_port == DEFAULT_PORT) ||
                       ((extra_port != 16'd0) && (req.dest_port == extra_port));
   assign open_match = (req.addr_family == FAMILY_INET) && port_match;

   assign pkt_live = req.call_ok && cur.tracked && (cur.state != HS_INVALID);

   // Entry update
   always_comb begin
      nxt  = cur;
      emit = 1'b0;
      case (req.action)
         ACT_OPEN: begin
            if (open_match) begin
               nxt.tracked   = 1'b1;
               nxt.state     = HS_CONNECTING;
               nxt.confirmed = 1'b0;
            end
         end
         ACT_CLOSE: begin
            nxt.tracked = 1'b0;
         end
         ACT_PACKET: begin
            if (pkt_live) begin
               case (cur.state)
                  HS_CONNECTING: begin
                     if (req.direction && (req.seq_byte == SEQ_GREETING) &&
                         (len_clamped > GREETING_MIN_LEN) &&
                         (req.type_byte == TYPE_GREETING)) begin
                        nxt.state = HS_GREETING;
                     end
                  end
                  HS_GREETING: begin
                     if (!req.direction && (req.seq_byte == SEQ_CLIENT_REPLY)) begin
                        nxt.state = HS_AUTH;
                     end
                  end
                  HS_AUTH: begin
                     if (req.direction && (len_clamped > HEADER_LEN)) begin
                        if (req.type_byte == TYPE_OK) begin
                           nxt.state     = HS_ESTABLISHED;
                           nxt.confirmed = 1'b1;
                        end else if (req.type_byte == TYPE_ERR) begin
                           nxt.state     = HS_INVALID;
                           nxt.confirmed = 1'b0;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               // a connection turned invalid reports nothing
               if (nxt.state != HS_INVALID) begin
                  if (hdr_bad) begin
                     if (nxt.state == HS_CONNECTING) begin
                        nxt.state = HS_INVALID;
                     end
                  end else begin
                     emit = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign upd.entry = nxt;
   assign upd.emit  = emit;

   // Event word
   assign rsp.event_slot      = req.conn_slot;
   assign rsp.event_direction = req.direction;
   assign rsp.event_length    = len_clamped[14:0];
   assign rsp.event_seq       = req.seq_byte;
   assign rsp.event_state     = nxt.state;
   assign rsp.event_confirmed = nxt.confirmed;

endmodule

`default_nettype wire

// File: rtl/db_handshake_flow_classifier.sv
// Top level of the handshake flow classifier: slot table, update stage and result register.
`default_nettype none

// Tracks the handshake of each connection slot in a table of NUM_SLOTS entries held in
// one RAM. A new word can be accepted while its predecessor is written back, unless the
// result register holds an event not yet taken. The table is read when the word is
// accepted, the entry is updated and written back when the word leaves the update stage,
// and any event lands in the result register at that same edge. Each word does a single
// RAM read-modify-write; a bypass register covers back-to-back words on the same slot.
// After reset the block clears the table, one entry per cycle, with req_ready low;
// configuration writes are taken during that time.

module db_handshake_flow_classifier #(
   parameter int NUM_SLOTS = dbhfc_pkg::NUM_SLOTS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire dbhfc_pkg::req_type req_payload,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      dbhfc_pkg::rsp_type rsp_payload,
   input  wire logic               csr_write_enable,
   input  wire logic [15:0]        csr_write_data
);

   import dbhfc_pkg::*;

   localparam int ADDR_W  = $clog2(NUM_SLOTS);
   localparam int ENTRY_W = $bits(entry_type);

   logic [15:0]       extra_port_ff;
   logic              clr_busy_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic              s1_valid_ff;
   req_type           s1_req_ff;
   logic              fwd_valid_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   entry_type         fwd_entry_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic               req_accept;
   logic               s1_adv;
   logic [31:0]        req_slot_wide;
   logic [31:0]        s1_slot_wide;
   logic [ADDR_W-1:0]  req_addr;
   logic [ADDR_W-1:0]  s1_addr;
   logic               s1_in_range;
   logic [ENTRY_W-1:0] ram_rd_data;
   entry_type          cur_entry;
   upd_type            upd;
   rsp_type            upd_rsp;
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic               s1_wr;

   // Handshake
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !clr_busy_ff && (!s1_valid_ff || s1_adv);
   assign req_accept = req_valid && req_ready;

   // Slot to table address
   assign req_slot_wide = 32'(req_payload.conn_slot);
   assign s1_slot_wide  = 32'(s1_req_ff.conn_slot);
   assign req_addr      = req_slot_wide[ADDR_W-1:0];
   assign s1_addr       = s1_slot_wide[ADDR_W-1:0];
   assign s1_in_range   = s1_slot_wide < 32'(NUM_SLOTS);

   // Table RAM: clearing pass owns the write port until done
   assign s1_wr       = s1_adv && s1_in_range;
   assign ram_wr_en   = clr_busy_ff || s1_wr;
   assign ram_wr_addr = clr_busy_ff ? clr_addr_ff : s1_addr;
   assign ram_wr_data = clr_busy_ff ? ENTRY_W'(0) : upd.entry;

   dbhfc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_accept),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   // Bypass the last write when the read may have missed it
   assign cur_entry = (fwd_valid_ff && (fwd_addr_ff == s1_addr)) ? fwd_entry_ff
                                                                  : entry_type'(ram_rd_data);

   dbhfc_update u_update (
      .req        (s1_req_ff),
      .cur        (cur_entry),
      .extra_port (extra_port_ff),
      .upd        (upd),
      .rsp        (upd_rsp)
   );

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         extra_port_ff <= DEFAULT_PORT;
      end else if (csr_write_enable) begin
         extra_port_ff <= csr_write_data;
      end
   end

   // Clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == ADDR_W'(NUM_SLOTS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
      end
   end

   // Update stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_payload;
      end
   end

   // Last write to the table
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (s1_wr) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_wr) begin
         fwd_addr_ff  <= s1_addr;
         fwd_entry_ff <= upd.entry;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= upd.emit && s1_in_range;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_ff <= upd_rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire
